[design/wrng_pkg.sv]
// Shared types, constants and constant functions for the WELL512a generator.
// No dependencies; every design module imports this package.
package wrng_pkg;

	localparam int unsigned POOL_DEPTH = 16;
	localparam int unsigned IDX_W      = $clog2(POOL_DEPTH);
	localparam int unsigned WORD_W     = 32;

	typedef logic [WORD_W-1:0]                  word_t;
	typedef logic [IDX_W-1:0]                   idx_t;
	typedef logic [POOL_DEPTH-1:0][WORD_W-1:0]  pool_t;
	typedef logic [POOL_DEPTH-1:0]              flags_t;

	localparam word_t TEMPER_MASK = 32'hDA44_2D24;
	localparam word_t EXPAND_MUL  = 32'd1812433253;

	typedef enum logic [1:0] {
		OP_DRAW = 2'd0,
		OP_SEED = 2'd1,
		OP_LOAD = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_ALIGN
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic draw;        // run one generator step
		logic seed_start;  // write word 0 from the seed, clear rotor and counter
		logic expand;      // produce the next seed expansion word
		logic load_latch;  // capture a word load, clear the counter
		logic align_step;  // rotate the pool by one toward rotor zero
		logic load_write;  // write the captured word (rotor is zero)
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic rot_zero;
		logic exp_last;
		logic out_hold;
	} dp_sts_t;

	function automatic word_t expand_step(input word_t prev, input idx_t k);
		word_t mixed;
		mixed = prev ^ (prev >> 30);
		return word_t'(EXPAND_MUL * mixed) + word_t'(k);
	endfunction

	// Pool contents for a given seed; only used for constants at elaboration
	function automatic pool_t expand_pool(input word_t seed);
		pool_t p;
		p[0] = seed;
		for (int k = 1; k < POOL_DEPTH; k++) begin
			p[k] = expand_step(p[k-1], idx_t'(k));
		end
		return p;
	endfunction

	function automatic flags_t zero_flags(input pool_t p);
		flags_t f;
		for (int k = 0; k < POOL_DEPTH; k++) begin
			f[k] = (p[k] == '0);
		end
		return f;
	endfunction

endpackage

[design/wrng_in_if.sv]
// Request channel of the WELL512a generator: valid/ready plus operation fields.
// Depends on nothing outside itself.
interface wrng_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] word_value;
	logic [3:0]  word_index;

	modport source (output valid, output operation, output word_value, output word_index,
		input ready);
	modport sink (input valid, input operation, input word_value, input word_index,
		output ready);
endinterface

[design/wrng_out_if.sv]
// Result channel of the WELL512a generator: valid/ready plus draw result fields.
// Depends on nothing outside itself.
interface wrng_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] random_value;
	logic [31:0] draw_count;
	logic        state_invalid;

	modport source (output valid, output random_value, output draw_count,
		output state_invalid, input ready);
	modport sink (input valid, input random_value, input draw_count,
		input state_invalid, output ready);
endinterface

[design/well512a_random_generator_core.sv]
// WELL512a pseudo-random generator. A draw (operation 0) is taken and its
// result appears in the output register in the cycle after; while results are
// taken, one draw is accepted every cycle. A single-value seed (operation 1)
// keeps the request channel busy while it takes the seed and then produces the
// fifteen expansion words, one per cycle, with the single 32-bit multiplier.
// A word load (operation 2) takes the request, then the pool, kept rotated to
// the current rotor position, is turned back one word a cycle until the rotor
// reads zero, and then the word is written. Operation 3 is accepted and dropped.
// Requests wait while a result is held unaccepted.
// Reset loads the pool expanded from seed zero and needs no startup pass.
module well512a_random_generator_core
	import wrng_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	wrng_in_if.sink   req,
	wrng_out_if.source rsp
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	wrng_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_op    (req.operation),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wrng_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.word_value (req.word_value),
		.word_index (req.word_index),
		.rsp        (rsp)
	);

endmodule

[design/wrng_ctrl.sv]
// Sequencer of the WELL512a generator: accepts requests, runs seed expansion
// and pool re-alignment. Uses wrng_pkg; drives the datapath by dp_cmd_t.
module wrng_ctrl
	import wrng_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_op,
	output logic       in_ready,
	input  dp_sts_t    sts,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;
	op_t    op;
	logic   accept;

	assign op     = op_t'(in_op);
	assign accept = in_valid && (state_q == ST_IDLE) && !sts.out_hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_SEED: state_d = ST_EXPAND;
						OP_LOAD: state_d = ST_ALIGN;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_EXPAND: begin
				if (sts.exp_last) state_d = ST_IDLE;
			end
			ST_ALIGN: begin
				if (sts.rot_zero) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = !sts.out_hold;
				if (accept) begin
					unique case (op)
						OP_DRAW: cmd.draw       = 1'b1;
						OP_SEED: cmd.seed_start = 1'b1;
						OP_LOAD: cmd.load_latch = 1'b1;
						default: cmd            = '0;
					endcase
				end
			end
			ST_EXPAND: cmd.expand = 1'b1;
			ST_ALIGN: begin
				// rotate until the pool sits at rotor zero, then write the word
				if (sts.rot_zero) begin
					cmd.load_write = 1'b1;
				end else begin
					cmd.align_step = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end

endmodule

[design/wrng_dp.sv]
// Datapath of the WELL512a generator: rotating 16-word pool, seed expansion
// multiplier, draw counter and result register. Uses wrng_pkg and wrng_out_if.
module wrng_dp
	import wrng_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic [31:0] word_value,
	input  logic [3:0]  word_index,
	wrng_out_if.source  rsp
);

	localparam pool_t  SEED0_POOL  = expand_pool('0);
	localparam flags_t SEED0_ZEROS = zero_flags(SEED0_POOL);

	// Position k of the pool holds pool word (rotor + k); a draw rotates by one.
	pool_t  pool_q;
	flags_t zero_q;
	idx_t   rot_q;
	word_t  cnt_q;
	word_t  prev_q;
	idx_t   kx_q;
	word_t  ld_val_q;
	idx_t   ld_idx_q;

	logic   rsp_valid_q;
	word_t  rsp_value_q;
	word_t  rsp_count_q;
	logic   rsp_bad_q;

	word_t  w0, w9, w13, old;
	word_t  mixa, mixb, fresh, temper, newb;
	word_t  exp_word;
	idx_t   pos_a0, pos_a1;
	logic   bad;

	assign w0  = pool_q[0];
	assign w9  = pool_q[9];
	assign w13 = pool_q[13];
	assign old = pool_q[POOL_DEPTH-1];

	assign mixa   = w0 ^ w13 ^ (w0 << 16) ^ (w13 << 15);
	assign mixb   = w9 ^ (w9 >> 11);
	assign fresh  = mixa ^ mixb;
	assign temper = fresh ^ ((fresh << 5) & TEMPER_MASK);
	assign newb   = old ^ mixa ^ temper ^ (old << 2) ^ (mixa << 18) ^ (mixb << 28);

	assign exp_word = expand_step(prev_q, kx_q);

	// physical positions of pool words 0 and 1
	assign pos_a0 = idx_t'(0) - rot_q;
	assign pos_a1 = idx_t'(1) - rot_q;
	assign bad    = zero_q[pos_a0] && zero_q[pos_a1];

	assign sts.rot_zero = (rot_q == '0);
	assign sts.exp_last = (kx_q == idx_t'(POOL_DEPTH - 1));
	assign sts.out_hold = rsp_valid_q && !rsp.ready;

	assign rsp.valid         = rsp_valid_q;
	assign rsp.random_value  = rsp_value_q;
	assign rsp.draw_count    = rsp_count_q;
	assign rsp.state_invalid = rsp_bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= SEED0_POOL;
			zero_q <= SEED0_ZEROS;
			rot_q  <= '0;
			cnt_q  <= '0;
			kx_q   <= '0;
		end else begin
			if (cmd.draw) begin
				pool_q <= {pool_q[POOL_DEPTH-2:1], fresh, newb};
				zero_q <= {zero_q[POOL_DEPTH-2:1], (fresh == '0), (newb == '0)};
				rot_q  <= rot_q - idx_t'(1);
				cnt_q  <= cnt_q + word_t'(1);
			end else if (cmd.seed_start) begin
				pool_q[0] <= word_value;
				zero_q[0] <= (word_value == '0);
				rot_q     <= '0;
				cnt_q     <= '0;
				kx_q      <= idx_t'(1);
			end else if (cmd.expand) begin
				pool_q[kx_q] <= exp_word;
				zero_q[kx_q] <= (exp_word == '0);
				kx_q         <= kx_q + idx_t'(1);
			end else if (cmd.load_latch) begin
				cnt_q <= '0;
			end else if (cmd.align_step) begin
				pool_q <= {pool_q[POOL_DEPTH-2:0], pool_q[POOL_DEPTH-1]};
				zero_q <= {zero_q[POOL_DEPTH-2:0], zero_q[POOL_DEPTH-1]};
				rot_q  <= rot_q - idx_t'(1);
			end else if (cmd.load_write) begin
				pool_q[ld_idx_q] <= ld_val_q;
				zero_q[ld_idx_q] <= (ld_val_q == '0);
			end
		end
	end

	// expansion chain and load capture: payload only
	always_ff @(posedge clk) begin
		if (cmd.seed_start) begin
			prev_q <= word_value;
		end else if (cmd.expand) begin
			prev_q <= exp_word;
		end
		if (cmd.load_latch) begin
			ld_val_q <= word_value;
			ld_idx_q <= word_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.draw) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.draw) begin
			rsp_value_q <= newb;
			rsp_count_q <= cnt_q + word_t'(1);
			rsp_bad_q   <= bad;
		end
	end

endmodule

[design/wrng_checker.sv]
// Port-level checks for the WELL512a generator core, bound to the top level.
// Uses wrng_pkg for the operation codes.
module wrng_checker
	import wrng_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [1:0]  req_operation,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_random_value
);

	logic req_beat;
	assign req_beat = req_valid && req_ready;

	// a result shows up only right after a draw beat
	a_rsp_from_draw: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_beat && (req_operation == OP_DRAW)))
		else $error("result without a preceding draw");

	a_draw_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(req_beat && (req_operation == OP_DRAW)) |=> rsp_valid)
		else $error("draw beat gave no result");

	a_seed_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(req_beat && (req_operation != OP_DRAW)) |=> !rsp_valid)
		else $error("non-draw beat gave a result");

	a_seed_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_beat && (req_operation == OP_SEED)) |=> !req_ready)
		else $error("seed expansion did not hold off requests");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_random_value)))
		else $error("stalled result beat changed");

endmodule

bind well512a_random_generator_core wrng_checker u_wrng_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_operation    (req.operation),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_random_value (rsp.random_value)
);

[sim/well512a_random_generator_core_tb.sv]
// Testbench for well512a_random_generator_core: drives request beats, predicts every draw
// with a local WELL512a pool model and checks each result beat field by field.
// Depends on wrng_pkg, wrng_in_if and wrng_out_if from the design folder.
module well512a_random_generator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wrng_pkg::*;

	localparam int unsigned CLK_PERIOD    = 20;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam logic [1:0]  OP_UNUSED     = 2'd3;

	typedef struct packed {
		word_t value;
		word_t count;
		logic  invalid;
	} draw_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	wrng_in_if  req();
	wrng_out_if rsp();

	well512a_random_generator_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	word_t        pool_model [POOL_DEPTH];
	idx_t         rotor_model;
	word_t        draws_model;
	draw_result_t expected_draws [$];
	int unsigned  error_count    = 0;
	bit           idle_on        = 1'b1;
	int unsigned  rx_hold_cycles = 0;

	function automatic void seed_model(input word_t seed);
		pool_model[0] = seed;
		for (int k = 1; k < POOL_DEPTH; k++) begin
			pool_model[k] = EXPAND_MUL * (pool_model[k-1] ^ (pool_model[k-1] >> 30))
				+ word_t'(k);
		end
		rotor_model = '0;
		draws_model = '0;
	endfunction

	function automatic draw_result_t draw_model();
		idx_t         here;
		idx_t         back;
		word_t        w0, w13, w9, mixa, mixb, fresh, temper, old;
		draw_result_t r;
		r.invalid = (pool_model[0] == '0) && (pool_model[1] == '0);
		here   = rotor_model;
		w0     = pool_model[here];
		w13    = pool_model[idx_t'(here + idx_t'(13))];
		w9     = pool_model[idx_t'(here + idx_t'(9))];
		mixa   = w0 ^ w13 ^ (w0 << 16) ^ (w13 << 15);
		mixb   = w9 ^ (w9 >> 11);
		fresh  = mixa ^ mixb;
		temper = fresh ^ ((fresh << 5) & TEMPER_MASK);
		pool_model[here] = fresh;
		back   = idx_t'(here + idx_t'(15));
		old    = pool_model[back];
		pool_model[back] = old ^ mixa ^ temper ^ (old << 2) ^ (mixa << 18) ^ (mixb << 28);
		rotor_model = back;
		draws_model = draws_model + 32'd1;
		r.value = pool_model[back];
		r.count = draws_model;
		return r;
	endfunction

	function automatic void apply_request(input logic [1:0] op, input word_t value,
		input idx_t index);
		case (op)
			OP_DRAW: expected_draws.push_back(draw_model());
			OP_SEED: seed_model(value);
			OP_LOAD: begin
				pool_model[index] = value;
				rotor_model = '0;
				draws_model = '0;
			end
			default: ;
		endcase
	endfunction

	// Called at a falling edge; returns at a falling edge with valid still high
	// unless a gap was inserted.
	task automatic send_item(input logic [1:0] op, input word_t value, input idx_t index);
		int unsigned gap;
		req.valid      <= 1'b1;
		req.operation  <= op;
		req.word_value <= value;
		req.word_index <= index;
		do @(posedge clk); while (!req.ready);
		apply_request(op, value, index);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		while (expected_draws.size() != 0) @(negedge clk);
	endtask

	task automatic send_random_request();
		int unsigned pick;
		word_t       value;
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 7))
			0:       value = '0;
			1:       value = '1;
			default: value = $urandom();
		endcase
		if (pick < 78) begin
			send_item(OP_DRAW, $urandom(), idx_t'($urandom()));
		end else if (pick < 84) begin
			send_item(OP_SEED, value, idx_t'($urandom()));
		end else if (pick < 95) begin
			send_item(OP_LOAD, value, idx_t'($urandom_range(0, 15)));
		end else if (pick < 98) begin
			send_item(OP_UNUSED, value, idx_t'($urandom()));
		end else begin
			// zero the two words that mark a degenerate pool
			send_item(OP_LOAD, '0, idx_t'(0));
			send_item(OP_LOAD, '0, idx_t'(1));
		end
	endtask

	task automatic test_reset_pool();
		repeat (3) send_item(OP_DRAW, '0, '0);
	endtask

	task automatic test_seed_extremes();
		send_item(OP_SEED, '0, '0);
		send_item(OP_DRAW, '0, '0);
		send_item(OP_SEED, '1, '1);
		send_item(OP_DRAW, '1, '1);
		send_item(OP_DRAW, '0, '0);
		send_item(OP_SEED, 32'h8000_0001, '0);
		send_item(OP_DRAW, '0, '0);
	endtask

	task automatic test_word_loads();
		send_item(OP_LOAD, '1, idx_t'(15));
		send_item(OP_DRAW, '0, '0);
		send_item(OP_LOAD, 32'h5A5A_A5A5, idx_t'(0));
		send_item(OP_DRAW, '0, '0);
	endtask

	task automatic test_degenerate_pool();
		send_item(OP_LOAD, '0, idx_t'(0));
		send_item(OP_LOAD, '0, idx_t'(1));
		send_item(OP_DRAW, '0, '0);
		send_item(OP_DRAW, '0, '0);
	endtask

	task automatic test_unused_opcode();
		send_item(OP_UNUSED, '1, idx_t'(15));
		send_item(OP_DRAW, '0, '0);
	endtask

	task automatic test_random_traffic(input int unsigned count);
		repeat (count) send_random_request();
	endtask

	task automatic test_result_backpressure();
		idle_on = 1'b0;
		rx_hold_cycles = 120;
		repeat (48) send_item(OP_DRAW, $urandom(), idx_t'($urandom()));
		idle_on = 1'b1;
	endtask

	task automatic test_drain_pause();
		repeat (20) send_random_request();
		drain_results();
		repeat (20) send_random_request();
	endtask

	task automatic test_steady_tail();
		idle_on = 1'b0;
		repeat (300) send_random_request();
	endtask

	// result side: long holds on request, otherwise random stall bursts
	initial begin
		int unsigned stall;
		stall = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles != 0) begin
				rx_hold_cycles--;
				rsp.ready <= 1'b0;
			end else if (stall != 0) begin
				stall--;
				rsp.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 9) - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		draw_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_draws.size() == 0) begin
				$display("%0t: result beat with none expected, value %h count %h invalid %b",
					$time, rsp.random_value, rsp.draw_count, rsp.state_invalid);
				error_count++;
			end else begin
				want = expected_draws.pop_front();
				if (rsp.random_value !== want.value) begin
					$display("%0t: random_value expected %h actual %h",
						$time, want.value, rsp.random_value);
					error_count++;
				end
				if (rsp.draw_count !== want.count) begin
					$display("%0t: draw_count expected %h actual %h",
						$time, want.count, rsp.draw_count);
					error_count++;
				end
				if (rsp.state_invalid !== want.invalid) begin
					$display("%0t: state_invalid expected %b actual %b",
						$time, want.invalid, rsp.state_invalid);
					error_count++;
				end
			end
		end
	end

	initial begin
		req.valid      = 1'b0;
		req.operation  = OP_DRAW;
		req.word_value = '0;
		req.word_index = '0;
		seed_model('0);
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_pool();
		test_seed_extremes();
		test_word_loads();
		test_degenerate_pool();
		test_unused_opcode();
		test_random_traffic(900);
		test_result_backpressure();
		test_drain_pause();
		test_steady_tail();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("[well512a_random_generator_core] OK");
		end else begin
			$display("[well512a_random_generator_core] ERROR");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("[well512a_random_generator_core] ERROR");
		$finish;
	end

endmodule
